FILE: rtl/bas_pkg.sv
// Shared types, widths and codes for the buzzer alarm pattern sequencer.
// No dependencies; every other file imports this package.
package bas_pkg;

    localparam int CLK_W  = 27;
    localparam int FREQ_W = 17;
    localparam int MS_W   = 16;
    localparam int REP_W  = 8;
    localparam int MODE_W = 2;
    localparam int OWN_W  = 2;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam int DIV_STEPS = CLK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TONE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NOTIFY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd3;

    localparam logic [OWN_W-1:0] OWN_NONE     = 2'd0;
    localparam logic [OWN_W-1:0] OWN_SINGLE   = 2'd1;
    localparam logic [OWN_W-1:0] OWN_NOTIFY   = 2'd2;
    localparam logic [OWN_W-1:0] OWN_SHUTDOWN = 2'd3;

    localparam logic [2:0] REG_SYS_CLK     = 3'd0;
    localparam logic [2:0] REG_ALARM_FREQ  = 3'd1;
    localparam logic [2:0] REG_NOTIFY_TONE = 3'd2;
    localparam logic [2:0] REG_NOTIFY_GAP  = 3'd3;
    localparam logic [2:0] REG_NOTIFY_REP  = 3'd4;
    localparam logic [2:0] REG_SHUT_TONE   = 3'd5;
    localparam logic [2:0] REG_SHUT_GAP    = 3'd6;
    localparam logic [2:0] REG_SHUT_REP    = 3'd7;

    localparam logic [CLK_W-1:0]  RST_SYS_CLK     = 27'd80000000;
    localparam logic [FREQ_W-1:0] RST_ALARM_FREQ  = 17'd2000;
    localparam logic [MS_W-1:0]   RST_NOTIFY_TONE = 16'd200;
    localparam logic [MS_W-1:0]   RST_NOTIFY_GAP  = 16'd3000;
    localparam logic [REP_W-1:0]  RST_NOTIFY_REP  = 8'd20;
    localparam logic [MS_W-1:0]   RST_SHUT_TONE   = 16'd500;
    localparam logic [MS_W-1:0]   RST_SHUT_GAP    = 16'd200;
    localparam logic [REP_W-1:0]  RST_SHUT_REP    = 8'd10;

    typedef struct packed {
        logic [CLK_W-1:0]  sys_clk;
        logic [FREQ_W-1:0] alarm_freq;
        logic [MS_W-1:0]   notify_tone;
        logic [MS_W-1:0]   notify_gap;
        logic [REP_W-1:0]  notify_rep;
        logic [MS_W-1:0]   shut_tone;
        logic [MS_W-1:0]   shut_gap;
        logic [REP_W-1:0]  shut_rep;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } status_t;

endpackage

FILE: rtl/bas_regs.sv
// APB configuration registers of the buzzer sequencer.
// Depends on bas_pkg.
module bas_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bas_pkg::ADDR_W-1:0] paddr,
    input  logic [bas_pkg::DATA_W-1:0] pwdata,
    output logic [bas_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output bas_pkg::cfg_t             cfg
);
    import bas_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sys_clk     <= RST_SYS_CLK;
            cfg_reg.alarm_freq  <= RST_ALARM_FREQ;
            cfg_reg.notify_tone <= RST_NOTIFY_TONE;
            cfg_reg.notify_gap  <= RST_NOTIFY_GAP;
            cfg_reg.notify_rep  <= RST_NOTIFY_REP;
            cfg_reg.shut_tone   <= RST_SHUT_TONE;
            cfg_reg.shut_gap    <= RST_SHUT_GAP;
            cfg_reg.shut_rep    <= RST_SHUT_REP;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SYS_CLK:     cfg_reg.sys_clk     <= pwdata[CLK_W-1:0];
                REG_ALARM_FREQ:  cfg_reg.alarm_freq  <= pwdata[FREQ_W-1:0];
                REG_NOTIFY_TONE: cfg_reg.notify_tone <= pwdata[MS_W-1:0];
                REG_NOTIFY_GAP:  cfg_reg.notify_gap  <= pwdata[MS_W-1:0];
                REG_NOTIFY_REP:  cfg_reg.notify_rep  <= pwdata[REP_W-1:0];
                REG_SHUT_TONE:   cfg_reg.shut_tone   <= pwdata[MS_W-1:0];
                REG_SHUT_GAP:    cfg_reg.shut_gap    <= pwdata[MS_W-1:0];
                REG_SHUT_REP:    cfg_reg.shut_rep    <= pwdata[REP_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SYS_CLK:     prdata = DATA_W'(cfg_reg.sys_clk);
            REG_ALARM_FREQ:  prdata = DATA_W'(cfg_reg.alarm_freq);
            REG_NOTIFY_TONE: prdata = DATA_W'(cfg_reg.notify_tone);
            REG_NOTIFY_GAP:  prdata = DATA_W'(cfg_reg.notify_gap);
            REG_NOTIFY_REP:  prdata = DATA_W'(cfg_reg.notify_rep);
            REG_SHUT_TONE:   prdata = DATA_W'(cfg_reg.shut_tone);
            REG_SHUT_GAP:    prdata = DATA_W'(cfg_reg.shut_gap);
            REG_SHUT_REP:    prdata = DATA_W'(cfg_reg.shut_rep);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/bas_div.sv
// Restoring serial divider, one quotient bit per cycle: clock / frequency.
// Depends on bas_pkg.
module bas_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bas_pkg::CLK_W-1:0]  dividend,
    input  logic [bas_pkg::FREQ_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [bas_pkg::CLK_W-1:0]  quotient
);
    import bas_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CLK_W-1:0]     quo_reg, quo_next;
    logic [FREQ_W-1:0]    rem_reg, rem_next;
    logic [FREQ_W-1:0]    dsr_reg, dsr_next;
    logic [FREQ_W:0]      trial;
    logic [FREQ_W+1:0]    diff;
    logic                 ge;
    logic                 last;

    assign trial    = {rem_reg, quo_reg[CLK_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, dsr_reg};
    assign ge       = ~diff[FREQ_W+1];
    assign last     = cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign busy     = busy_reg;
    assign done     = busy_reg && last;
    assign quotient = {quo_reg[CLK_W-2:0], ge};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = quotient;
            rem_next  = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            busy_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

FILE: rtl/bas_datapath.sv
// Sequencer datapath: timeout, pattern counters, PWM period/match and result beat.
// Depends on bas_pkg and bas_div.
module bas_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bas_pkg::cfg_t             cfg,
    input  bas_pkg::cmd_t             cmd,
    output bas_pkg::status_t          status,
    input  logic [bas_pkg::MODE_W-1:0] mode,
    input  logic [bas_pkg::FREQ_W-1:0] freq_hz,
    input  logic [bas_pkg::MS_W-1:0]   duration_ms,
    output logic [bas_pkg::CLK_W-1:0]  period_count,
    output logic [bas_pkg::CLK_W-1:0]  match_count,
    output logic                      tone_on,
    output logic [bas_pkg::OWN_W-1:0]  timer_owner,
    output logic                      pattern_ended
);
    import bas_pkg::*;

    logic [MS_W-1:0]   rem_reg, rem_next;
    logic [OWN_W-1:0]  owner_reg, owner_next;
    logic              n_phase_reg, n_phase_next;
    logic [REP_W-1:0]  n_count_reg, n_count_next;
    logic              s_phase_reg, s_phase_next;
    logic [REP_W-1:0]  s_count_reg, s_count_next;
    logic [CLK_W-1:0]  period_reg, period_next;
    logic [CLK_W-1:0]  match_reg, match_next;
    logic              ended_reg, ended_next;

    logic [CLK_W-1:0]  o_period_reg;
    logic [CLK_W-1:0]  o_match_reg;
    logic              o_tone_reg;
    logic [OWN_W-1:0]  o_owner_reg;
    logic              o_ended_reg;

    logic              snd_set;
    logic [FREQ_W-1:0] snd_freq;
    logic [CLK_W-2:0]  half_clk;
    logic [FREQ_W-1:0] f_cl;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [CLK_W-1:0]  div_q;

    assign half_clk = cfg.sys_clk[CLK_W-1:1];
    assign f_cl     = (CLK_W'(snd_freq) > CLK_W'(half_clk)) ?
                      half_clk[FREQ_W-1:0] : snd_freq;
    assign div_start = cmd.accept && snd_set && (f_cl != '0);

    bas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg.sys_clk),
        .divisor  (f_cl),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign status.div_busy = div_busy;

    always_comb
    begin
        logic             sel_notify;
        logic             pat_phase;
        logic [REP_W-1:0] pat_count;
        logic [REP_W-1:0] pat_reps;
        logic [MS_W-1:0]  pat_tone;
        logic [MS_W-1:0]  pat_gap;
        logic             pat_phase_next;
        logic [REP_W-1:0] pat_count_next;

        rem_next     = rem_reg;
        owner_next   = owner_reg;
        n_phase_next = n_phase_reg;
        n_count_next = n_count_reg;
        s_phase_next = s_phase_reg;
        s_count_next = s_count_reg;
        ended_next   = 1'b0;
        snd_set      = 1'b0;
        snd_freq     = '0;

        sel_notify     = owner_reg == OWN_NOTIFY;
        pat_phase      = sel_notify ? n_phase_reg : s_phase_reg;
        pat_count      = sel_notify ? n_count_reg : s_count_reg;
        pat_reps       = sel_notify ? cfg.notify_rep : cfg.shut_rep;
        pat_tone       = sel_notify ? cfg.notify_tone : cfg.shut_tone;
        pat_gap        = sel_notify ? cfg.notify_gap : cfg.shut_gap;
        pat_phase_next = ~pat_phase;
        pat_count_next = pat_count;

        case (mode)
            MODE_TICK:
            begin
                if (owner_reg != OWN_NONE)
                begin
                    if (rem_reg > MS_W'(1))
                    begin
                        rem_next = rem_reg - 1'b1;
                    end
                    else
                    begin
                        rem_next = '0;
                        if (owner_reg == OWN_SINGLE)
                        begin
                            owner_next = OWN_NONE;
                            snd_set    = 1'b1;
                        end
                        else
                        begin
                            snd_set = 1'b1;
                            if (!pat_phase)
                            begin
                                rem_next = pat_gap;
                            end
                            else if (pat_count < pat_reps)
                            begin
                                snd_freq       = cfg.alarm_freq;
                                rem_next       = pat_tone;
                                pat_count_next = pat_count + 1'b1;
                            end
                            else
                            begin
                                owner_next     = OWN_NONE;
                                pat_count_next = '0;
                                ended_next     = 1'b1;
                            end
                            if (sel_notify)
                            begin
                                n_phase_next = pat_phase_next;
                                n_count_next = pat_count_next;
                            end
                            else
                            begin
                                s_phase_next = pat_phase_next;
                                s_count_next = pat_count_next;
                            end
                        end
                    end
                end
            end
            MODE_TONE:
            begin
                snd_set    = 1'b1;
                snd_freq   = freq_hz;
                owner_next = OWN_SINGLE;
                rem_next   = duration_ms;
            end
            MODE_NOTIFY:
            begin
                snd_set    = 1'b1;
                snd_freq   = cfg.alarm_freq;
                owner_next = OWN_NOTIFY;
                rem_next   = cfg.notify_tone;
            end
            MODE_SHUTDOWN:
            begin
                snd_set    = 1'b1;
                snd_freq   = cfg.alarm_freq;
                owner_next = OWN_SHUTDOWN;
                rem_next   = cfg.shut_tone;
            end
            default:
            begin
                snd_set = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        period_next = period_reg;
        match_next  = match_reg;
        if (cmd.accept && snd_set && (f_cl == '0))
        begin
            period_next = cfg.sys_clk;
            match_next  = cfg.sys_clk;
        end
        else if (div_done)
        begin
            period_next = div_q;
            match_next  = {1'b0, div_q[CLK_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            owner_reg   <= OWN_NONE;
            n_phase_reg <= 1'b0;
            n_count_reg <= '0;
            s_phase_reg <= 1'b0;
            s_count_reg <= '0;
            ended_reg   <= 1'b0;
            period_reg  <= RST_SYS_CLK;
            match_reg   <= RST_SYS_CLK;
        end
        else
        begin
            if (cmd.accept)
            begin
                rem_reg     <= rem_next;
                owner_reg   <= owner_next;
                n_phase_reg <= n_phase_next;
                n_count_reg <= n_count_next;
                s_phase_reg <= s_phase_next;
                s_count_reg <= s_count_next;
                ended_reg   <= ended_next;
            end
            period_reg <= period_next;
            match_reg  <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            o_period_reg <= period_reg;
            o_match_reg  <= match_reg;
            o_tone_reg   <= period_reg != match_reg;
            o_owner_reg  <= owner_reg;
            o_ended_reg  <= ended_reg;
        end
    end

    assign period_count  = o_period_reg;
    assign match_count   = o_match_reg;
    assign tone_on       = o_tone_reg;
    assign timer_owner   = o_owner_reg;
    assign pattern_ended = o_ended_reg;

endmodule

FILE: rtl/bas_ctrl.sv
// Sequencer controller: input handshake, wait on divider, output beat valid.
// Depends on bas_pkg.
module bas_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  bas_pkg::status_t status,
    output bas_pkg::cmd_t    cmd
);
    import bas_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign s_tready    = state_reg == S_IDLE;
    assign out_free    = !out_valid_reg || m_tready;
    assign cmd.accept  = s_tvalid && s_tready;
    assign cmd.publish = (state_reg == S_BUSY) && !status.div_busy && out_free;
    assign m_tvalid    = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (cmd.publish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/buzzer_alarm_pattern_sequencer.sv
// Buzzer alarm pattern sequencer, top level: APB registers, controller, datapath.
// The result beat is registered once the divider is idle and the output is free; the
// 27-step serial divider runs only when a tone starts, not when silenced or unchanged.
// One input item is processed at a time; the next beat is taken after the result
// is registered, even while that result still waits on m_tready.
// Reset (rst_n, async, active low): registers to defaults, silent, no timeout pending.
module buzzer_alarm_pattern_sequencer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bas_pkg::ADDR_W-1:0] paddr,
    input  logic [bas_pkg::DATA_W-1:0] pwdata,
    output logic [bas_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [39:0]               s_tdata,   // freq_hz[16:0], duration_ms[32:17]
    input  logic [1:0]                s_tuser,   // mode[1:0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [55:0]               m_tdata,   // period_count[26:0], match_count[53:27]
    output logic [2:0]                m_tuser,   // tone_on[0], timer_owner[2:1]
    output logic                      m_tlast    // pattern_ended
);
    import bas_pkg::*;

    cfg_t             cfg;
    cmd_t             cmd;
    status_t          status;
    logic [CLK_W-1:0] period_count;
    logic [CLK_W-1:0] match_count;
    logic             tone_on;
    logic [OWN_W-1:0] timer_owner;
    logic             pattern_ended;

    bas_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bas_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .mode          (s_tuser[MODE_W-1:0]),
        .freq_hz       (s_tdata[FREQ_W-1:0]),
        .duration_ms   (s_tdata[FREQ_W+MS_W-1:FREQ_W]),
        .period_count  (period_count),
        .match_count   (match_count),
        .tone_on       (tone_on),
        .timer_owner   (timer_owner),
        .pattern_ended (pattern_ended)
    );

    assign m_tdata = {2'b00, match_count, period_count};
    assign m_tuser = {timer_owner, tone_on};
    assign m_tlast = pattern_ended;

endmodule

FILE: rtl/bas_checker.sv
// Port-level checks for the buzzer alarm pattern sequencer, bound to the top level.
// Depends on bas_pkg.
module bas_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import bas_pkg::*;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input beat taken while previous item in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_tone_half: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            m_tdata[53:27] == {1'b0, m_tdata[26:1]})
        else $error("tone match is not half the period");

    a_silent_equal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[53:27] == m_tdata[26:0])
        else $error("silent result with match differing from period");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[2:1] == OWN_NONE && !m_tuser[0])
        else $error("pattern end with timeout pending or tone on");

endmodule

bind buzzer_alarm_pattern_sequencer bas_checker u_bas_checker (.*);

FILE: dv/buzzer_tone_checker.sv
`timescale 1ns / 1ps
// Checker for the buzzer alarm pattern sequencer: tracks register writes, predicts
// each result beat from the accepted input beats and compares it with the seen beat.
// Depends on bas_pkg for widths, mode, owner and register codes.
module buzzer_tone_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bas_pkg::ADDR_W-1:0] paddr,
    input  logic [bas_pkg::DATA_W-1:0] pwdata,
    input  logic                       pready,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [39:0]                s_tdata,   // freq_hz[16:0], duration_ms[32:17]
    input  logic [1:0]                 s_tuser,   // mode[1:0]
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [55:0]                m_tdata,   // period_count[26:0], match_count[53:27]
    input  logic [2:0]                 m_tuser,   // tone_on[0], timer_owner[2:1]
    input  logic                       m_tlast,   // pattern_ended
    output int                         fail_count,
    output int                         pending
);
    import bas_pkg::*;

    typedef struct packed {
        logic [CLK_W-1:0] period_cnt;
        logic [CLK_W-1:0] match_cnt;
        logic             tone_on;
        logic [OWN_W-1:0] owner;
        logic             ended;
    } tone_result_t;

    cfg_t             cfg;
    logic [MS_W-1:0]  remaining_ms;
    logic [OWN_W-1:0] owner;
    logic             pat_phase [0:1];
    logic [REP_W-1:0] pat_count [0:1];
    logic [CLK_W-1:0] period_reg;
    logic [CLK_W-1:0] match_reg;
    tone_result_t     expected_tones [$];
    int               mismatches;

    function automatic void apply_tone(input logic [CLK_W-1:0] freq);
        logic [CLK_W-1:0] clk_hz;
        logic [CLK_W-1:0] f;
        clk_hz = cfg.sys_clk;
        f      = freq;
        if (f > (clk_hz >> 1))
            f = clk_hz >> 1;
        if (f == '0)
        begin
            period_reg = clk_hz;
            match_reg  = clk_hz;
        end
        else
        begin
            period_reg = clk_hz / f;
            match_reg  = period_reg >> 1;
        end
    endfunction

    // sel 0: notify pattern, sel 1: shutdown pattern
    function automatic logic step_pattern(input logic sel);
        logic [REP_W-1:0] reps;
        logic [MS_W-1:0]  tone_ms;
        logic [MS_W-1:0]  gap_ms;
        logic             fin;
        reps    = sel ? cfg.shut_rep  : cfg.notify_rep;
        tone_ms = sel ? cfg.shut_tone : cfg.notify_tone;
        gap_ms  = sel ? cfg.shut_gap  : cfg.notify_gap;
        fin     = 1'b0;
        owner   = OWN_NONE;
        if (!pat_phase[sel])
        begin
            apply_tone('0);
            owner        = sel ? OWN_SHUTDOWN : OWN_NOTIFY;
            remaining_ms = gap_ms;
        end
        else if (pat_count[sel] < reps)
        begin
            apply_tone(cfg.alarm_freq);
            owner          = sel ? OWN_SHUTDOWN : OWN_NOTIFY;
            remaining_ms   = tone_ms;
            pat_count[sel] = pat_count[sel] + 1'b1;
        end
        else
        begin
            apply_tone('0);
            pat_count[sel] = '0;
            fin            = 1'b1;
        end
        pat_phase[sel] = ~pat_phase[sel];
        return fin;
    endfunction

    function automatic tone_result_t predict_beat(input logic [MODE_W-1:0] mode,
                                                  input logic [FREQ_W-1:0] freq,
                                                  input logic [MS_W-1:0]   dur);
        tone_result_t r;
        logic         ended;
        ended = 1'b0;
        case (mode)
            MODE_TICK:
                if (owner != OWN_NONE)
                begin
                    if (remaining_ms > 1)
                        remaining_ms = remaining_ms - 1'b1;
                    else
                    begin
                        remaining_ms = '0;
                        if (owner == OWN_SINGLE)
                        begin
                            owner = OWN_NONE;
                            apply_tone('0);
                        end
                        else
                            ended = step_pattern(owner == OWN_SHUTDOWN);
                    end
                end
            MODE_TONE:
            begin
                apply_tone(freq);
                owner        = OWN_SINGLE;
                remaining_ms = dur;
            end
            MODE_NOTIFY:
            begin
                apply_tone(cfg.alarm_freq);
                owner        = OWN_NOTIFY;
                remaining_ms = cfg.notify_tone;
            end
            MODE_SHUTDOWN:
            begin
                apply_tone(cfg.alarm_freq);
                owner        = OWN_SHUTDOWN;
                remaining_ms = cfg.shut_tone;
            end
            default: ;
        endcase
        r.period_cnt = period_reg;
        r.match_cnt  = match_reg;
        r.tone_on    = (period_reg != match_reg);
        r.owner      = owner;
        r.ended      = ended;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tone_result_t seen;
        tone_result_t want;
        if (!rst_n)
        begin
            cfg.sys_clk     = RST_SYS_CLK;
            cfg.alarm_freq  = RST_ALARM_FREQ;
            cfg.notify_tone = RST_NOTIFY_TONE;
            cfg.notify_gap  = RST_NOTIFY_GAP;
            cfg.notify_rep  = RST_NOTIFY_REP;
            cfg.shut_tone   = RST_SHUT_TONE;
            cfg.shut_gap    = RST_SHUT_GAP;
            cfg.shut_rep    = RST_SHUT_REP;
            remaining_ms    = '0;
            owner           = OWN_NONE;
            pat_phase[0]    = 1'b0;
            pat_phase[1]    = 1'b0;
            pat_count[0]    = '0;
            pat_count[1]    = '0;
            period_reg      = RST_SYS_CLK;
            match_reg       = RST_SYS_CLK;
            expected_tones.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                case (paddr[4:2])
                    REG_SYS_CLK:     cfg.sys_clk     = pwdata[CLK_W-1:0];
                    REG_ALARM_FREQ:  cfg.alarm_freq  = pwdata[FREQ_W-1:0];
                    REG_NOTIFY_TONE: cfg.notify_tone = pwdata[MS_W-1:0];
                    REG_NOTIFY_GAP:  cfg.notify_gap  = pwdata[MS_W-1:0];
                    REG_NOTIFY_REP:  cfg.notify_rep  = pwdata[REP_W-1:0];
                    REG_SHUT_TONE:   cfg.shut_tone   = pwdata[MS_W-1:0];
                    REG_SHUT_GAP:    cfg.shut_gap    = pwdata[MS_W-1:0];
                    REG_SHUT_REP:    cfg.shut_rep    = pwdata[REP_W-1:0];
                    default: ;
                endcase
            if (m_tvalid && m_tready)
            begin
                seen = {m_tdata[26:0], m_tdata[53:27], m_tuser[0], m_tuser[2:1], m_tlast};
                if (expected_tones.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: unexpected result beat period %0d match %0d ",
                                  "tone %0d owner %0d end %0d"},
                                 $time, seen.period_cnt, seen.match_cnt, seen.tone_on,
                                 seen.owner, seen.ended);
                end
                else
                begin
                    want = expected_tones.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch expected period %0d match %0d tone %0d ",
                                      "owner %0d end %0d, got period %0d match %0d tone %0d ",
                                      "owner %0d end %0d"},
                                     $time, want.period_cnt, want.match_cnt, want.tone_on,
                                     want.owner, want.ended, seen.period_cnt, seen.match_cnt,
                                     seen.tone_on, seen.owner, seen.ended);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_tones.push_back(predict_beat(s_tuser, s_tdata[16:0], s_tdata[32:17]));
        end
        fail_count <= mismatches;
        pending    <= expected_tones.size();
    end

endmodule

FILE: dv/buzzer_alarm_pattern_sequencer_tb.sv
`timescale 1ns / 1ps
// Top of the buzzer alarm pattern sequencer testbench: clock, reset, register writes,
// directed and random input beats with idle and stall phases, and the verdict.
// Depends on bas_pkg, the sequencer RTL and buzzer_tone_checker.
module buzzer_alarm_pattern_sequencer_tb;
    import bas_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 270;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [39:0]       s_tdata  = '0;   // freq_hz[16:0], duration_ms[32:17]
    logic [1:0]        s_tuser  = '0;   // mode[1:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;         // period_count[26:0], match_count[53:27]
    logic [2:0]        m_tuser;         // tone_on[0], timer_owner[2:1]
    logic              m_tlast;         // pattern_ended
    int                fail_count;
    int                pending;
    int                idle_pct    = 0;
    int                stall_pct   = 0;
    int                cycle_count = 0;

    buzzer_alarm_pattern_sequencer u_dut (.*);

    buzzer_tone_checker u_checker (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [FREQ_W-1:0] freq,
                             input logic [MS_W-1:0] dur);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, dur, freq};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // hold input until every result beat is back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_span(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    function automatic logic [DATA_W-1:0] pick_ms();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(1, 65535);
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [DATA_W-1:0] pick_repeats();
        if ($urandom_range(0, 19) == 0)
            return 255;
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return 17'd100000;
        return FREQ_W'($urandom_range(1, 100000));
    endfunction

    function automatic logic [MS_W-1:0] pick_dur();
        if ($urandom_range(0, 9) < 8)
            return MS_W'($urandom_range(0, 6));
        return MS_W'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int phase;
        int sent;
        int roll;
        int burst;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: idle tick, zero freq and zero timeout, replacement, patterns
        send_item(MODE_TICK, '0, '0);
        send_item(MODE_TONE, '0, '0);
        send_item(MODE_TICK, '0, '0);
        send_item(MODE_TONE, 17'd100000, 16'd65535);
        send_item(MODE_TONE, 17'd1, 16'd1);
        send_item(MODE_TICK, '0, '0);
        send_item(MODE_NOTIFY, '0, '0);
        send_item(MODE_TICK, '0, '0);
        send_item(MODE_SHUTDOWN, '0, '0);
        send_item(MODE_TONE, 17'd2000, 16'd2);
        drain();

        // minimum settings: run notify to its end, interrupt and resume shutdown
        write_reg(REG_SYS_CLK, 32'd1000000);
        write_reg(REG_ALARM_FREQ, 32'd1);
        write_reg(REG_NOTIFY_TONE, 32'd1);
        write_reg(REG_NOTIFY_GAP, 32'd1);
        write_reg(REG_NOTIFY_REP, 32'd1);
        write_reg(REG_SHUT_TONE, 32'd1);
        write_reg(REG_SHUT_GAP, 32'd1);
        write_reg(REG_SHUT_REP, 32'd2);
        send_item(MODE_NOTIFY, '0, '0);
        repeat (4) send_item(MODE_TICK, '0, '0);
        send_item(MODE_SHUTDOWN, '0, '0);
        repeat (2) send_item(MODE_TICK, '0, '0);
        send_item(MODE_TONE, 17'd100000, 16'd3);
        send_item(MODE_SHUTDOWN, '0, '0);
        repeat (2) send_item(MODE_TICK, '0, '0);
        drain();

        // lower repeats below the count and change the clock mid-tone
        write_reg(REG_SHUT_REP, 32'd0);
        write_reg(REG_SYS_CLK, 32'd120000000);
        repeat (2) send_item(MODE_TICK, '0, '0);
        drain();

        write_reg(REG_ALARM_FREQ, 32'd100000);
        write_reg(REG_NOTIFY_TONE, 32'd65535);
        write_reg(REG_NOTIFY_GAP, 32'd65535);
        write_reg(REG_NOTIFY_REP, 32'd255);
        write_reg(REG_SHUT_TONE, 32'd65535);
        write_reg(REG_SHUT_GAP, 32'd65535);
        write_reg(REG_SHUT_REP, 32'd255);
        send_item(MODE_NOTIFY, '0, '0);
        send_item(MODE_TICK, '0, '0);
        send_item(MODE_TONE, 17'd100000, 16'd65535);
        drain();

        // slow clock so the frequency clamp bites
        write_reg(REG_SYS_CLK, 32'd100001);
        send_item(MODE_TONE, 17'd60000, 16'd1);
        send_item(MODE_SHUTDOWN, '0, '0);
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 72 : (phase == 3) ? 22 : 0;
            stall_pct <= (phase == 2) ? 72 : (phase == 3) ? 22 : 0;
            write_reg(REG_SYS_CLK, pick_span(1000000, 120000000));
            write_reg(REG_ALARM_FREQ, pick_span(1, 100000));
            write_reg(REG_NOTIFY_TONE, pick_ms());
            write_reg(REG_NOTIFY_GAP, pick_ms());
            write_reg(REG_NOTIFY_REP, pick_repeats());
            write_reg(REG_SHUT_TONE, pick_ms());
            write_reg(REG_SHUT_GAP, pick_ms());
            write_reg(REG_SHUT_REP, pick_repeats());
            sent = 0;
            while (sent < RANDOM_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 25)
                begin
                    burst = $urandom_range(3, 40);
                    repeat (burst)
                        send_item(MODE_TICK, pick_freq(), MS_W'($urandom_range(0, 65535)));
                    sent += burst;
                end
                else
                begin
                    if (roll < 75)
                        send_item(MODE_TICK, pick_freq(), MS_W'($urandom_range(0, 65535)));
                    else if (roll < 85)
                        send_item(MODE_TONE, pick_freq(), pick_dur());
                    else if (roll < 92)
                        send_item(MODE_NOTIFY, pick_freq(), pick_dur());
                    else
                        send_item(MODE_SHUTDOWN, pick_freq(), pick_dur());
                    sent++;
                end
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/bas_pkg.sv
rtl/bas_regs.sv
rtl/bas_div.sv
rtl/bas_datapath.sv
rtl/bas_ctrl.sv
rtl/buzzer_alarm_pattern_sequencer.sv
rtl/bas_checker.sv
dv/buzzer_tone_checker.sv
dv/buzzer_alarm_pattern_sequencer_tb.sv
